FILE: hw/rtl/dhti_pkg.sv
package dhti_pkg;

    localparam int WORD_W = 64;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGN_ENABLED = 2'd2;

    localparam logic [WORD_W-1:0] MIN_VALUE_RST = 64'h0000_0000_0000_0000;
    localparam logic [WORD_W-1:0] MAX_VALUE_RST = 64'h0000_0000_FFFF_FFFF;
    localparam logic              SIGN_EN_RST   = 1'b1;

    // ascii codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [WORD_W-1:0] min_value;
        logic [WORD_W-1:0] max_value;
    } clamp_cfg_t;

endpackage

FILE: hw/rtl/dhti_clamp.sv
module dhti_clamp
    import dhti_pkg::*;
(
    input  clamp_cfg_t        cfg,
    input  logic [WORD_W-1:0] magnitude,
    input  logic              negate,
    output logic [WORD_W-1:0] result
);

    logic              below_min;
    logic              above_max;
    logic              min_above_max;
    logic              max_on;
    logic [WORD_W-1:0] clamped;

    // compares run in parallel instead of clamping low then high
    assign below_min     = magnitude < cfg.min_value;
    assign above_max     = magnitude > cfg.max_value;
    assign min_above_max = cfg.min_value > cfg.max_value;
    assign max_on        = cfg.max_value != '0;

    always_comb
    begin
        if (below_min)
        begin
            clamped = (max_on && min_above_max) ? cfg.max_value : cfg.min_value;
        end
        else
        begin
            clamped = (max_on && above_max) ? cfg.max_value : magnitude;
        end
    end

    assign result = negate ? ('0 - clamped) : clamped;

endmodule

FILE: hw/rtl/decimal_hex_text_to_integer.sv
// a terminating byte is registered in the input byte register, then its
// clamped result is registered in the output register
// throughput: one byte per clock, set by the accumulator update
// between the input byte register and the state registers; a terminating byte
// waits in the input register while a result is held, which stalls the input
// reset: clamp and sign registers take their defaults, the parser waits for
// the first byte of a number, no byte or result is pending
module decimal_hex_text_to_integer
    import dhti_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           char_code,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_W-1:0]    number_value,
    output logic                 was_hex
);

    typedef enum logic [2:0] {
        PH_START,
        PH_DEC_FIRST,
        PH_DEC_ZERO,
        PH_DEC_RUN,
        PH_HEX_FIRST,
        PH_HEX_ZERO,
        PH_HEX_TAKE,
        PH_HEX_RUN
    } phase_t;

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_dec(b) || ((b >= CH_LO_A) && (b <= CH_LO_F))
            || ((b >= CH_UP_A) && (b <= CH_UP_F));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (is_dec(b))
        begin
            d = b - CH_0;
        end
        else if ((b >= CH_LO_A) && (b <= CH_LO_F))
        begin
            d = b - CH_LO_A + 8'd10;
        end
        else if ((b >= CH_UP_A) && (b <= CH_UP_F))
        begin
            d = b - CH_UP_A + 8'd10;
        end
        return d[3:0];
    endfunction

    clamp_cfg_t        clamp_cfg_reg;
    logic              sign_en_reg;

    logic              byte_valid_reg;
    logic [7:0]        byte_reg;

    phase_t            phase_reg, phase_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic              minus_reg, minus_next;
    logic              hex_reg, hex_next;
    logic              finish;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_value_reg;
    logic              out_hex_reg;

    logic              out_free;
    logic              step_fire;
    logic              load_out;
    logic [WORD_W-1:0] clamp_result;
    logic [7:0]        dec_diff;
    logic [WORD_W-1:0] dec_step;
    logic [WORD_W-1:0] hex_step;

    assign out_free  = !out_valid_reg || out_ready;
    assign step_fire = byte_valid_reg && (!finish || out_free);
    assign load_out  = step_fire && finish;
    assign in_ready  = !byte_valid_reg || step_fire;

    assign dec_diff = byte_reg - CH_0;
    assign dec_step = (acc_reg << 3) + (acc_reg << 1) + {{(WORD_W-4){1'b0}}, dec_diff[3:0]};
    assign hex_step = (acc_reg << 4) + {{(WORD_W-4){1'b0}}, hex_val(byte_reg)};

    // the accumulator is still zero in both zero phases, so runs continue from it
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        hex_next   = hex_reg;
        finish     = 1'b0;
        case (phase_reg)
            PH_START, PH_DEC_FIRST:
            begin
                if ((phase_reg == PH_START) && sign_en_reg && (byte_reg == CH_MINUS))
                begin
                    minus_next = 1'b1;
                    phase_next = PH_DEC_FIRST;
                end
                else if (byte_reg == CH_0)
                begin
                    phase_next = PH_DEC_ZERO;
                end
                else
                begin
                    // any byte counts here, with wraparound
                    acc_next   = {{(WORD_W-8){1'b0}}, byte_reg}
                               - {{(WORD_W-8){1'b0}}, CH_0};
                    phase_next = PH_DEC_RUN;
                end
            end
            PH_DEC_ZERO, PH_DEC_RUN:
            begin
                if ((phase_reg == PH_DEC_ZERO) && (byte_reg == CH_X))
                begin
                    hex_next   = 1'b1;
                    phase_next = PH_HEX_FIRST;
                end
                else if (is_dec(byte_reg))
                begin
                    acc_next   = dec_step;
                    phase_next = PH_DEC_RUN;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            PH_HEX_FIRST, PH_HEX_TAKE:
            begin
                if ((phase_reg == PH_HEX_FIRST) && (byte_reg == CH_0))
                begin
                    phase_next = PH_HEX_ZERO;
                end
                else
                begin
                    acc_next   = hex_step;
                    phase_next = PH_HEX_RUN;
                end
            end
            PH_HEX_ZERO, PH_HEX_RUN:
            begin
                if ((phase_reg == PH_HEX_ZERO) && (byte_reg == CH_X))
                begin
                    // repeated prefix, next byte is the forced first digit
                    phase_next = PH_HEX_TAKE;
                end
                else if (is_hex(byte_reg))
                begin
                    acc_next   = hex_step;
                    phase_next = PH_HEX_RUN;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
        if (finish)
        begin
            phase_next = PH_START;
            acc_next   = '0;
            minus_next = 1'b0;
            hex_next   = 1'b0;
        end
    end

    dhti_clamp u_clamp (
        .cfg       (clamp_cfg_reg),
        .magnitude (acc_reg),
        .negate    (minus_reg),
        .result    (clamp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_cfg_reg.min_value <= MIN_VALUE_RST;
            clamp_cfg_reg.max_value <= MAX_VALUE_RST;
            sign_en_reg             <= SIGN_EN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MIN_VALUE:    clamp_cfg_reg.min_value <= cfg_data;
                REG_MAX_VALUE:    clamp_cfg_reg.max_value <= cfg_data;
                REG_SIGN_ENABLED: sign_en_reg             <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            byte_reg       <= '0;
            phase_reg      <= PH_START;
            acc_reg        <= '0;
            minus_reg      <= 1'b0;
            hex_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_hex_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                byte_valid_reg <= in_valid;
            end
            if (in_valid && in_ready)
            begin
                byte_reg <= char_code;
            end
            if (step_fire)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                minus_reg <= minus_next;
                hex_reg   <= hex_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_value_reg <= clamp_result;
                out_hex_reg   <= hex_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign number_value = out_value_reg;
    assign was_hex      = out_hex_reg;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import dhti_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT = 6;
    localparam int LONG_HOLD = 250;
    localparam int CHARS_PER_SETTING = 95;
    localparam int N_SETTINGS = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        PH_START,
        PH_DEC_FIRST,
        PH_DEC_ZERO,
        PH_DEC_RUN,
        PH_HEX_FIRST,
        PH_HEX_ZERO,
        PH_HEX_TAKE,
        PH_HEX_RUN
    } parse_phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              hex;
    } number_t;

    typedef struct packed {
        logic [7:0]        ch;
        logic              typed;
        logic [WORD_W-1:0] value;
        logic              hex;
    } script_row_t;

    typedef struct packed {
        logic [WORD_W-1:0] min_value;
        logic [WORD_W-1:0] max_value;
        logic              sign_en;
    } setting_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data = '0;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           char_code = '0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [WORD_W-1:0]    number_value;
    logic                 was_hex;

    // expected result typed into the directed script, travels with the byte
    logic                 known_valid = 1'b0;
    logic [WORD_W-1:0]    known_value = '0;
    logic                 known_hex = 1'b0;

    // parser copy used for prediction
    logic [WORD_W-1:0] acc = '0;
    parse_phase_t      phase = PH_START;
    logic              minus_seen = 1'b0;
    logic              hex_mode = 1'b0;
    logic [WORD_W-1:0] clamp_min = MIN_VALUE_RST;
    logic [WORD_W-1:0] clamp_max = MAX_VALUE_RST;
    logic              sign_en = SIGN_EN_RST;

    number_t pending_numbers[$];

    int  errors = 0;
    int  numbers_checked = 0;
    int  chars_sent = 0;
    int  cycle_count = 0;
    bit  quiet = 1'b0;
    bit  long_hold_req = 1'b0;

    script_row_t script[27] = '{
        '{"7",      1'b0, 64'd0, 1'b0},
        '{" ",      1'b1, 64'd7, 1'b0},
        '{CH_MINUS, 1'b0, 64'd0, 1'b0},
        '{"5",      1'b0, 64'd0, 1'b0},
        '{",",      1'b1, 64'hFFFF_FFFF_FFFF_FFFB, 1'b0},
        '{CH_0,     1'b0, 64'd0, 1'b0},
        '{";",      1'b1, 64'd0, 1'b0},
        '{CH_0,     1'b0, 64'd0, 1'b0},
        '{CH_X,     1'b0, 64'd0, 1'b0},
        '{CH_UP_F,  1'b0, 64'd0, 1'b0},
        '{",",      1'b1, 64'hF, 1'b1},
        '{CH_0,     1'b0, 64'd0, 1'b0},
        '{CH_X,     1'b0, 64'd0, 1'b0},
        '{CH_0,     1'b0, 64'd0, 1'b0},
        '{CH_X,     1'b0, 64'd0, 1'b0},
        '{CH_LO_A,  1'b0, 64'd0, 1'b0},
        '{" ",      1'b1, 64'hA, 1'b1},
        // second minus is taken as a digit and the run clamps to the maximum
        '{CH_MINUS, 1'b0, 64'd0, 1'b0},
        '{CH_MINUS, 1'b0, 64'd0, 1'b0},
        '{"3",      1'b0, 64'd0, 1'b0},
        '{" ",      1'b0, 64'd0, 1'b0},
        '{8'hFF,    1'b0, 64'd0, 1'b0},
        '{8'h00,    1'b0, 64'd0, 1'b0},
        // non-digit in the first hex position adds nothing
        '{CH_0,     1'b0, 64'd0, 1'b0},
        '{CH_X,     1'b0, 64'd0, 1'b0},
        '{"G",      1'b0, 64'd0, 1'b0},
        '{" ",      1'b1, 64'd0, 1'b1}
    };

    decimal_hex_text_to_integer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .number_value (number_value),
        .was_hex      (was_hex)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit is_dec_char(input logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic bit is_hex_char(input logic [7:0] b);
        return is_dec_char(b) || (b >= CH_LO_A && b <= CH_LO_F)
            || (b >= CH_UP_A && b <= CH_UP_F);
    endfunction

    function automatic logic [WORD_W-1:0] hex_weight(input logic [7:0] b);
        if (is_dec_char(b))
            return WORD_W'(b - CH_0);
        if (b >= CH_LO_A && b <= CH_LO_F)
            return WORD_W'(b - CH_LO_A + 10);
        if (b >= CH_UP_A && b <= CH_UP_F)
            return WORD_W'(b - CH_UP_A + 10);
        return '0;
    endfunction

    function automatic number_t close_number();
        number_t res;
        logic [WORD_W-1:0] v;
        v = acc;
        if (v < clamp_min)
            v = clamp_min;
        if (clamp_max != '0 && v > clamp_max)
            v = clamp_max;
        if (minus_seen)
            v = -v;
        res.value = v;
        res.hex = hex_mode;
        acc = '0;
        phase = PH_START;
        minus_seen = 1'b0;
        hex_mode = 1'b0;
        return res;
    endfunction

    // advances the parser by one byte, returns 1 when a number is completed
    function automatic bit parse_char(input logic [7:0] b, output number_t res);
        parse_phase_t ph;
        res = '0;
        ph = phase;
        if (ph == PH_START)
        begin
            if (sign_en && b == CH_MINUS)
            begin
                minus_seen = 1'b1;
                phase = PH_DEC_FIRST;
                return 1'b0;
            end
            ph = PH_DEC_FIRST;
        end
        if (ph == PH_DEC_FIRST)
        begin
            // first position takes any byte
            if (b == CH_0)
                phase = PH_DEC_ZERO;
            else
            begin
                acc = WORD_W'(b) - WORD_W'(CH_0);
                phase = PH_DEC_RUN;
            end
            return 1'b0;
        end
        if (ph == PH_DEC_ZERO)
        begin
            if (b == CH_X)
            begin
                hex_mode = 1'b1;
                phase = PH_HEX_FIRST;
                return 1'b0;
            end
            acc = '0;
            ph = PH_DEC_RUN;
        end
        if (ph == PH_DEC_RUN)
        begin
            if (is_dec_char(b))
            begin
                acc = acc * 10 + WORD_W'(b - CH_0);
                phase = PH_DEC_RUN;
                return 1'b0;
            end
            res = close_number();
            return 1'b1;
        end
        if (ph == PH_HEX_FIRST)
        begin
            if (b == CH_0)
            begin
                phase = PH_HEX_ZERO;
                return 1'b0;
            end
            ph = PH_HEX_TAKE;
        end
        if (ph == PH_HEX_TAKE)
        begin
            acc = (acc << 4) + hex_weight(b);
            phase = PH_HEX_RUN;
            return 1'b0;
        end
        if (ph == PH_HEX_ZERO)
        begin
            // repeated prefix is skipped once
            if (b == CH_X)
            begin
                phase = PH_HEX_TAKE;
                return 1'b0;
            end
            acc = '0;
        end
        if (is_hex_char(b))
        begin
            acc = (acc << 4) + hex_weight(b);
            phase = PH_HEX_RUN;
            return 1'b0;
        end
        res = close_number();
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] random_hex_digit();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return 8'(CH_0 + r);
        if (r < 16)
            return 8'(CH_LO_A + r - 10);
        return 8'(CH_UP_A + r - 16);
    endfunction

    function automatic logic [7:0] random_end_char(input bit hex_num);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (hex_num ? is_hex_char(c) : is_dec_char(c))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // offers one byte and returns right after the transfer edge
    task automatic send_char(input logic [7:0] b, input logic typed,
                             input logic [WORD_W-1:0] value, input logic hex);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= b;
        known_valid <= typed;
        known_value <= value;
        known_hex <= hex;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_char(b, 1'b0, '0, 1'b0);
    endtask

    task automatic send_number();
        bit hex_num;
        int n_digits;
        if ($urandom_range(0, 3) == 0)
            send_plain(CH_MINUS);
        hex_num = ($urandom_range(0, 2) == 0);
        if (hex_num)
        begin
            send_plain(CH_0);
            send_plain(CH_X);
            if ($urandom_range(0, 4) == 0)
            begin
                send_plain(CH_0);
                send_plain(CH_X);
            end
        end
        // long runs overflow the 64-bit accumulator
        if ($urandom_range(0, 9) < 8)
            n_digits = $urandom_range(1, 5);
        else
            n_digits = $urandom_range(6, hex_num ? 18 : 22);
        repeat (n_digits)
        begin
            if (hex_num)
                send_plain(random_hex_digit());
            else
                send_plain(8'(CH_0 + $urandom_range(0, 9)));
        end
        send_plain(random_end_char(hex_num));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MIN_VALUE:    clamp_min = data;
            REG_MAX_VALUE:    clamp_max = data;
            REG_SIGN_ENABLED: sign_en = data[0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // waits for every outstanding number, then lets trailing bytes settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_numbers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        number_t want;
        number_t calc;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_numbers.size() == 0)
                begin
                    $error("unexpected result: number_value %h was_hex %b",
                           number_value, was_hex);
                    errors++;
                end
                else
                begin
                    want = pending_numbers.pop_front();
                    numbers_checked++;
                    if (number_value !== want.value)
                    begin
                        $error("number_value: expected %h, got %h", want.value, number_value);
                        errors++;
                    end
                    if (was_hex !== want.hex)
                    begin
                        $error("was_hex: expected %b, got %b", want.hex, was_hex);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (parse_char(char_code, calc))
                begin
                    if (known_valid)
                    begin
                        want.value = known_value;
                        want.hex = known_hex;
                        pending_numbers.push_back(want);
                    end
                    else
                        pending_numbers.push_back(calc);
                end
            end
        end
    end

    // receiver with random stalls and one long hold-off on request
    initial
    begin : sink
        int hold;
        hold = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            else
                hold = pick_gap();
            out_ready <= (hold == 0);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("decimal_hex_text_to_integer regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        setting_t settings[N_SETTINGS];
        int target;
        settings[0] = '{64'd0, 64'd0, 1'b1};
        settings[1] = '{'1, 64'd0, 1'b0};
        settings[2] = '{'1, 64'd1, 1'b1};
        settings[3] = '{64'($urandom_range(0, 1000)), 64'($urandom_range(1, 100000)), 1'b1};
        settings[4] = '{{$urandom, $urandom}, {$urandom, $urandom}, 1'b0};
        settings[5] = '{MIN_VALUE_RST, MAX_VALUE_RST, SIGN_EN_RST};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_char(script[i].ch, script[i].typed, script[i].value, script[i].hex);
        drain();

        for (int s = 0; s < N_SETTINGS; s++)
        begin
            write_reg(REG_MIN_VALUE, settings[s].min_value);
            write_reg(REG_MAX_VALUE, settings[s].max_value);
            // upper bits of the sign write carry random noise
            write_reg(REG_SIGN_ENABLED, {$urandom, 31'($urandom_range(0, 32'h7FFF_FFFF)),
                                         settings[s].sign_en});
            if (s == 1)
                write_reg(REG_UNUSED, {$urandom, $urandom});
            quiet = (s == 3);
            if (s == 0)
                long_hold_req = 1'b1;
            target = chars_sent + CHARS_PER_SETTING;
            while (chars_sent < target)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 4)) send_plain(8'($urandom_range(0, 255)));
                else
                    send_number();
            end
            drain();
        end

        $display("covered %0d text bytes and %0d numbers over %0d register settings",
                 chars_sent, numbers_checked, N_SETTINGS + 1);
        if (errors == 0)
            $display("decimal_hex_text_to_integer regression: pass");
        else
            $display("decimal_hex_text_to_integer regression: fail");
        $finish;
    end

endmodule
